### hw/rtl/dptt_pkg.sv
// dptt_pkg: shared types, codes and constants of the depth-preferred transposition table
// used by dptt_front, dptt_back and the top level; depends on nothing else

package dptt_pkg;

	// table geometry default
	localparam int unsigned INDEX_BITS_DEFAULT = 12;

	// distance from a mate bound inside which a score counts as a mate score
	localparam int MATE_MARGIN = 100;

	// reset values of the mate bounds
	localparam logic signed [15:0] LOSE_SCORE_RESET = -16'sd32000;
	localparam logic signed [15:0] WIN_SCORE_RESET  = 16'sd32000;

	// configuration register indexes
	localparam logic CFG_LOSE_SCORE = 1'b0;
	localparam logic CFG_WIN_SCORE  = 1'b1;

	// request function codes
	localparam logic [1:0] FUNC_STORE = 2'd0;
	localparam logic [1:0] FUNC_PROBE = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	// response status codes
	localparam logic [1:0] RSP_MISS    = 2'd0;
	localparam logic [1:0] RSP_HIT     = 2'd1;
	localparam logic [1:0] RSP_SHALLOW = 2'd2;
	localparam logic [1:0] RSP_DONE    = 2'd3;

	// classified operation handed from front to back
	typedef enum logic [1:0] {
		OP_STORE,
		OP_PROBE,
		OP_CLEAR,
		OP_NOP
	} op_t;

	// back-end sequencer states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	// one queued command
	typedef struct packed {
		op_t                op;
		logic [63:0]        key;
		logic [6:0]         depth;
		logic [1:0]         flag;
		logic signed [15:0] score;
		logic [31:0]        mv;
		logic [7:0]         ply;
	} cmd_t;

	// one table entry as held in memory
	typedef struct packed {
		logic [63:0]        key;
		logic [6:0]         depth;
		logic signed [15:0] score;
		logic [1:0]         flag;
		logic [31:0]        mv;
	} entry_t;

	// one response
	typedef struct packed {
		logic [1:0]         status;
		logic [1:0]         flag;
		logic signed [15:0] score;
		logic [31:0]        mv;
	} rsp_t;

	// status from back end to front end
	typedef struct packed {
		logic init_busy;
	} back_status_t;

endpackage

### hw/rtl/dptt_ram.sv
// dptt_ram: generic single-port RAM with registered read data
// no dependencies

module dptt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one access per cycle, read or write
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/dptt_front.sv
// dptt_front: request acceptance, function decode and two-entry command queue
// depends on dptt_pkg

module dptt_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  logic [1:0]            func,
	input  logic [63:0]           position_key,
	input  logic [6:0]            search_depth,
	input  logic [1:0]            bound_flag,
	input  logic signed [15:0]    score_in,
	input  logic [31:0]           move_in,
	input  logic [7:0]            ply_distance,
	input  dptt_pkg::back_status_t back_status,
	output logic                  cmd_valid,
	output dptt_pkg::cmd_t        cmd,
	input  logic                  cmd_pop
);

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned PTR_W  = $clog2(QDEPTH);

	dptt_pkg::cmd_t     q_mem_q [QDEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     count_q;
	dptt_pkg::cmd_t     cmd_new;
	logic               push;

	// decode the function code
	always_comb begin
		cmd_new       = '0;
		cmd_new.key   = position_key;
		cmd_new.depth = search_depth;
		cmd_new.flag  = bound_flag;
		cmd_new.score = score_in;
		cmd_new.mv    = move_in;
		cmd_new.ply   = ply_distance;
		unique case (func)
			dptt_pkg::FUNC_STORE: begin
				cmd_new.op = dptt_pkg::OP_STORE;
			end
			dptt_pkg::FUNC_PROBE: begin
				cmd_new.op = dptt_pkg::OP_PROBE;
			end
			dptt_pkg::FUNC_CLEAR: begin
				cmd_new.op = dptt_pkg::OP_CLEAR;
			end
			default: begin
				cmd_new.op = dptt_pkg::OP_NOP;
			end
		endcase
	end

	// no transaction taken while the table is swept after reset
	assign req_ready = (count_q != (PTR_W+1)'(QDEPTH)) && !back_status.init_busy;
	assign push      = req_valid && req_ready;
	assign cmd_valid = (count_q != '0);
	assign cmd       = q_mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cmd_new;
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && cmd_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/dptt_back.sv
// dptt_back: table sequencer: read, compare, replace, mate correction and clearing sweep
// depends on dptt_pkg and dptt_ram

module dptt_back #(
	parameter int unsigned INDEX_BITS = dptt_pkg::INDEX_BITS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	input  dptt_pkg::cmd_t        cmd,
	output logic                  cmd_pop,
	input  logic signed [15:0]    lose_score,
	input  logic signed [15:0]    win_score,
	output dptt_pkg::back_status_t back_status,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output dptt_pkg::rsp_t        rsp
);

	localparam int unsigned DEPTH   = 2 ** INDEX_BITS;
	localparam int unsigned ENTRY_W = $bits(dptt_pkg::entry_t);

	dptt_pkg::state_t       state_q, state_d;
	logic [INDEX_BITS-1:0]  clr_idx_q;
	logic                   init_q;
	dptt_pkg::cmd_t         cmd_s1;
	logic                   rsp_valid_q;
	dptt_pkg::rsp_t         rsp_q;

	logic                   out_free;
	logic                   go;
	logic                   sweep_last;
	logic                   ram_en;
	logic                   ram_we;
	logic [INDEX_BITS-1:0]  ram_addr;
	logic [ENTRY_W-1:0]     ram_wdata;
	logic [ENTRY_W-1:0]     ram_rdata;
	dptt_pkg::entry_t       rd;
	dptt_pkg::entry_t       new_entry;
	logic                   rsp_load;
	dptt_pkg::rsp_t         rsp_d;

	logic signed [17:0]     s_ext;
	logic signed [17:0]     lose_lim;
	logic signed [17:0]     win_lim;
	logic signed [17:0]     adj;
	logic signed [17:0]     corr;
	logic signed [15:0]     sat;

	dptt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign rd         = ram_rdata;
	assign out_free   = !rsp_valid_q || rsp_ready;
	assign go         = (state_q == dptt_pkg::ST_IDLE) && cmd_valid && out_free;
	assign sweep_last = &clr_idx_q;

	// entry written by a store
	always_comb begin
		new_entry       = '0;
		new_entry.key   = cmd_s1.key;
		new_entry.depth = cmd_s1.depth;
		new_entry.score = cmd_s1.score;
		new_entry.flag  = cmd_s1.flag;
		new_entry.mv    = cmd_s1.mv;
	end

	// mate correction away from the bounds toward zero, then saturation
	always_comb begin
		s_ext    = {{2{rd.score[15]}}, rd.score};
		lose_lim = {{2{lose_score[15]}}, lose_score} + 18'sd100;
		win_lim  = {{2{win_score[15]}}, win_score} - 18'sd100;
		adj      = $signed({10'd0, cmd_s1.ply}) + $signed({11'd0, rd.depth});
		priority if (s_ext < lose_lim) begin
			corr = s_ext + adj;
		end else if (s_ext > win_lim) begin
			corr = s_ext - adj;
		end else begin
			corr = s_ext;
		end
		priority if (corr > 18'sd32767) begin
			sat = 16'sh7fff;
		end else if (corr < -18'sd32768) begin
			sat = -16'sh8000;
		end else begin
			sat = corr[15:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dptt_pkg::ST_CLEAR: begin
				if (sweep_last) begin
					state_d = dptt_pkg::ST_IDLE;
				end
			end
			dptt_pkg::ST_IDLE: begin
				if (go) begin
					unique case (cmd.op)
						dptt_pkg::OP_STORE,
						dptt_pkg::OP_PROBE: state_d = dptt_pkg::ST_EXEC;
						dptt_pkg::OP_CLEAR: state_d = dptt_pkg::ST_CLEAR;
						default:            state_d = dptt_pkg::ST_IDLE;
					endcase
				end
			end
			dptt_pkg::ST_EXEC: begin
				state_d = dptt_pkg::ST_IDLE;
			end
			default: begin
				state_d = dptt_pkg::ST_IDLE;
			end
		endcase
	end

	// memory control and response
	always_comb begin
		cmd_pop   = 1'b0;
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = cmd.key[INDEX_BITS-1:0];
		ram_wdata = '0;
		rsp_load  = 1'b0;
		rsp_d     = '0;
		unique case (state_q)
			dptt_pkg::ST_CLEAR: begin
				ram_en   = 1'b1;
				ram_we   = 1'b1;
				ram_addr = clr_idx_q;
			end
			dptt_pkg::ST_IDLE: begin
				if (go) begin
					cmd_pop = 1'b1;
					unique case (cmd.op)
						dptt_pkg::OP_STORE,
						dptt_pkg::OP_PROBE: begin
							ram_en = 1'b1;
						end
						dptt_pkg::OP_CLEAR: begin
							rsp_load     = 1'b1;
							rsp_d.status = dptt_pkg::RSP_DONE;
						end
						default: begin
							rsp_load     = 1'b1;
							rsp_d.status = dptt_pkg::RSP_MISS;
						end
					endcase
				end
			end
			dptt_pkg::ST_EXEC: begin
				rsp_load = 1'b1;
				ram_addr = cmd_s1.key[INDEX_BITS-1:0];
				if (cmd_s1.op == dptt_pkg::OP_STORE) begin
					rsp_d.status = dptt_pkg::RSP_DONE;
					// depth-preferred replacement
					if (cmd_s1.depth >= rd.depth) begin
						ram_en    = 1'b1;
						ram_we    = 1'b1;
						ram_wdata = new_entry;
					end
				end else if (rd.key == cmd_s1.key) begin
					rsp_d.score = sat;
					rsp_d.mv    = rd.mv;
					if (rd.depth >= cmd_s1.depth) begin
						rsp_d.status = dptt_pkg::RSP_HIT;
						rsp_d.flag   = rd.flag;
					end else begin
						rsp_d.status = dptt_pkg::RSP_SHALLOW;
					end
				end else begin
					rsp_d.status = dptt_pkg::RSP_MISS;
				end
			end
			default: begin
				rsp_load = 1'b0;
			end
		endcase
	end

	// sequencer and sweep registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dptt_pkg::ST_CLEAR;
			clr_idx_q <= '0;
			init_q    <= 1'b1;
		end else begin
			state_q <= state_d;
			if (state_q == dptt_pkg::ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (sweep_last) begin
					init_q <= 1'b0;
				end
			end else begin
				clr_idx_q <= '0;
			end
		end
	end

	// command held while its entry is read
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_s1 <= cmd;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid             = rsp_valid_q;
	assign rsp                   = rsp_q;
	assign back_status.init_busy = init_q;

endmodule

### hw/rtl/depth_preferred_transposition_table.sv
// depth_preferred_transposition_table: top level of the transposition table cache
// depends on dptt_pkg, dptt_front, dptt_back and dptt_ram
//
// Usage: requests enter on req_valid/req_ready with func selecting store, probe or
// clear; each request gives exactly one response on rsp_valid/rsp_ready with status,
// flag_out, score_out and move_out. Mate bounds are set through cfg_we/cfg_index/
// cfg_data (index 0 lose score, index 1 win score); the user must set them only while
// the block is idle, which the block itself does not enforce. A two-entry command
// queue parts the request side from the table sequencer. Store and probe: the entry
// is read from the single-port table memory, then compared, corrected and written back
// in the exec state; the sequencer takes no new command before that, and the response
// is registered in the output register. Clear: the response comes at once, then the
// sequencer sweeps 2^INDEX_BITS entries, one per cycle, before the next command runs;
// requests still queue. Reset: all control state is cleared and the same sweep over
// 2^INDEX_BITS entries zeroes the table; req_ready stays low until it ends. A stalled
// response holds in the output register; the queue keeps taking requests until it is
// full, then req_ready drops.

module depth_preferred_transposition_table #(
	parameter int unsigned INDEX_BITS = dptt_pkg::INDEX_BITS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [1:0]         func,
	input  logic [63:0]        position_key,
	input  logic [6:0]         search_depth,
	input  logic [1:0]         bound_flag,
	input  logic signed [15:0] score_in,
	input  logic [31:0]        move_in,
	input  logic [7:0]         ply_distance,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic [1:0]         status,
	output logic [1:0]         flag_out,
	output logic signed [15:0] score_out,
	output logic [31:0]        move_out
);

	logic signed [15:0]     lose_score_q;
	logic signed [15:0]     win_score_q;
	logic                   cmd_valid;
	dptt_pkg::cmd_t         cmd;
	logic                   cmd_pop;
	dptt_pkg::back_status_t back_status;
	dptt_pkg::rsp_t         rsp;

	// mate bound registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lose_score_q <= dptt_pkg::LOSE_SCORE_RESET;
			win_score_q  <= dptt_pkg::WIN_SCORE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dptt_pkg::CFG_LOSE_SCORE: lose_score_q <= cfg_data;
				dptt_pkg::CFG_WIN_SCORE:  win_score_q  <= cfg_data;
				default:                  lose_score_q <= lose_score_q;
			endcase
		end
	end

	dptt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.func         (func),
		.position_key (position_key),
		.search_depth (search_depth),
		.bound_flag   (bound_flag),
		.score_in     (score_in),
		.move_in      (move_in),
		.ply_distance (ply_distance),
		.back_status  (back_status),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop)
	);

	dptt_back #(
		.INDEX_BITS (INDEX_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop),
		.lose_score  (lose_score_q),
		.win_score   (win_score_q),
		.back_status (back_status),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp)
	);

	assign status    = rsp.status;
	assign flag_out  = rsp.flag;
	assign score_out = rsp.score;
	assign move_out  = rsp.mv;

	// the back end only takes a command that the queue holds
	a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command popped from an empty queue");

	// no command taken while a stalled response still sits in the output register
	a_pop_not_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !(rsp_valid && !rsp_ready))
		else $error("command taken while response stalled");

	// no request transaction during the post-reset sweep
	a_no_req_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		back_status.init_busy |-> !req_ready)
		else $error("request accepted during table initialisation");

	// a probe or store always answers after its entry read, through the exec state and output register
	a_exec_answers: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop && (cmd.op == dptt_pkg::OP_STORE || cmd.op == dptt_pkg::OP_PROBE))
		|=> ##1 rsp_valid)
		else $error("store or probe gave no response");

endmodule
